FILE: sv/rmf_pkg.sv
// ----------------------------------------------------------------------------
// rmf_pkg: shared types and constants of the running median filter
// Window length, sample and age widths, and the records that pass between
// neighboring cells of the sorted window.
// ----------------------------------------------------------------------------
package rmf_pkg;

   localparam int WINDOW   = 9;
   localparam int SAMPLE_W = 12;
   localparam int AGE_W    = $clog2(WINDOW);
   localparam int MID      = WINDOW / 2;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [AGE_W-1:0]    age_type;

   localparam age_type    AGE_MAX = age_type'(WINDOW - 1);
   localparam sample_type MARKER  = sample_type'(0);
   localparam sample_type SUBST   = sample_type'(1);

   // Stored contents of one cell.
   typedef struct packed {
      sample_type value;
      age_type    age;
   } cell_entry_type;

   // Handed from a cell to its right neighbor in the same cycle.
   typedef struct packed {
      logic           del_seen;  // oldest entry is at or left of this cell
      logic           above;     // compacted entry here is larger than the sample
      cell_entry_type packed_e;  // compacted entry at this position
   } cell_link_type;

endpackage

FILE: sv/rmf_cell.sv
// ----------------------------------------------------------------------------
// rmf_cell: one position of the sorted window
// Holds one value and its age. Each transaction, drop the oldest entry,
// close the gap, age the rest, and insert the new sample at its sorted place.
// ----------------------------------------------------------------------------
module rmf_cell import rmf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           last_cell,
   input  age_type        rst_age,
   input  sample_type     sample,
   input  cell_link_type  left_link,
   input  cell_entry_type right_entry,
   output cell_link_type  right_link,
   output cell_entry_type entry,
   output sample_type     next_value
);

   sample_type value_ff, value_in;
   age_type    age_ff, age_in;

   logic           del_seen;
   cell_entry_type compact;
   logic           above;

   function automatic age_type age_up(input age_type a);
      age_up = (a < AGE_MAX) ? a + age_type'(1) : a;
   endfunction

   always_comb begin
      del_seen = left_link.del_seen | (age_ff == AGE_MAX);
      compact  = del_seen ? right_entry : cell_entry_type'{value: value_ff, age: age_ff};
      above    = last_cell | (compact.value > sample);

      if (!advance) begin
         value_in = value_ff;
         age_in   = age_ff;
      end else if (!above) begin
         value_in = compact.value;
         age_in   = age_up(compact.age);
      end else if (left_link.above) begin
         // shift right by one to open the insertion slot
         value_in = left_link.packed_e.value;
         age_in   = age_up(left_link.packed_e.age);
      end else begin
         value_in = sample;
         age_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         age_ff   <= rst_age;
      end else begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

   assign right_link = '{del_seen: del_seen, above: above, packed_e: compact};
   assign entry      = '{value: value_ff, age: age_ff};
   assign next_value = value_in;

endmodule

FILE: sv/rmf_outq.sv
// ----------------------------------------------------------------------------
// rmf_outq: two-entry result buffer
// Output register plus one skid entry, so a new sample is taken while a
// finished median still waits on a stalled consumer.
// ----------------------------------------------------------------------------
module rmf_outq import rmf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  sample_type push_median,
   output logic       full,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output sample_type rsp_median
);

   logic       out_valid_ff, out_valid_in;
   sample_type out_median_ff, out_median_in;
   logic       skid_valid_ff, skid_valid_in;
   sample_type skid_median_ff, skid_median_in;

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_median_in  = out_median_ff;
      skid_valid_in  = skid_valid_ff;
      skid_median_in = skid_median_ff;
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_median_in = skid_median_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = push;
            out_median_in = push_median;
         end
      end else if (push) begin
         skid_valid_in  = 1'b1;
         skid_median_in = push_median;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_median_ff  <= out_median_in;
      skid_median_ff <= skid_median_in;
   end

   assign full       = skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_median = out_median_ff;

endmodule

FILE: sv/running_median_filter.sv
// ----------------------------------------------------------------------------
// running_median_filter: running median over a sliding window of samples
// A row of WINDOW cells keeps the last WINDOW samples sorted by value, each
// with its age. Every transaction retires the oldest entry and inserts the
// new sample; the middle cell gives the median.
//
//   channel  ports                         direction  payload
//   req      req_valid / req_stall         in         req_sample  [11:0]
//   rsp      rsp_valid / rsp_stall         out        rsp_median  [11:0]
//
// One sample per clock while req_stall is low. The window update is
// combinational across the cell chain: the delete flag and the compacted
// entries ripple cell to cell, so the chain length (WINDOW) sets its depth.
// The median reaches rsp via the output register, or the skid entry first.
// Reset clears the window to zeros with ages zero to WINDOW-1 in cell order;
// the median stays zero until more than half the window holds samples.
// A stalled rsp parks one result in a skid entry; req_stall rises only when
// that entry is occupied too.
// ----------------------------------------------------------------------------
module running_median_filter import rmf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  sample_type req_sample,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output sample_type rsp_median
);

   logic           advance;
   sample_type     sample;
   cell_link_type  link  [WINDOW+1];
   cell_entry_type entry [WINDOW];
   sample_type     next_value [WINDOW];
   logic           queue_full;

   // take the transaction only when the skid entry is free
   assign advance = req_valid & ~queue_full;
   assign req_stall = queue_full;

   // swap the reserved marker value for one
   assign sample = (req_sample == MARKER) ? SUBST : req_sample;

   // nothing deleted and nothing larger to the left of the first cell
   assign link[0] = '0;

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      cell_entry_type right_entry;

      if (i == WINDOW - 1) begin : g_end
         assign right_entry = '0;
      end else begin : g_mid
         assign right_entry = entry[i+1];
      end

      rmf_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .last_cell   (i == WINDOW - 1),
         .rst_age     (age_type'(i)),
         .sample      (sample),
         .left_link   (link[i]),
         .right_entry (right_entry),
         .right_link  (link[i+1]),
         .entry       (entry[i]),
         .next_value  (next_value[i])
      );
   end

   // capture the median of the updated window
   rmf_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .push        (advance),
      .push_median (next_value[MID]),
      .full        (queue_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_median  (rsp_median)
   );

   // -------------------------------------------------------------------------
   // checks
   // -------------------------------------------------------------------------
   logic [WINDOW-1:0] oldest_vec;
   logic [WINDOW-2:0] ordered_vec;

   always_comb begin
      for (int k = 0; k < WINDOW; k++) begin
         oldest_vec[k] = (entry[k].age == AGE_MAX);
      end
      for (int k = 0; k < WINDOW - 1; k++) begin
         ordered_vec[k] = (entry[k].value <= entry[k+1].value);
      end
   end

   a_one_oldest: assert property (@(posedge clock) disable iff (reset)
      $onehot(oldest_vec))
      else $error("window must hold exactly one oldest entry");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      &ordered_vec)
      else $error("window lost ascending order");

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid entry occupied with empty output register");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("accepted sample produced no result");

endmodule

FILE: sim/tb_running_median_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_running_median_filter: self-checking bench for the running median filter
// Drive converter samples through req with random gaps and take medians from
// rsp with random stalls. A scoreboard keeps its own sorted window with
// per-entry ages and holds the median due for every sample taken. Each
// median that comes back is compared with the oldest one pending. A long
// receiver hold-off during a back-to-back burst fills the skid entry and
// forces req_stall.
// ----------------------------------------------------------------------------
module tb_running_median_filter import rmf_pkg::*; ();

   localparam int NUM_RANDOM   = 1530;  // random samples after the directed run
   localparam int BURST_FIRST  = 380;   // sender goes back-to-back from here ...
   localparam int BURST_LAST   = 560;   // ... until just before here
   localparam int HOLD_AT      = 400;   // receiver freezes after this many medians
   localparam int HOLD_CYCLES  = 80;
   localparam int SEGMENT      = 64;    // transactions per idling mode
   localparam int IDLE_LIMIT   = 1000;  // cycles without any transaction
   localparam int DRAIN_CYCLES = 4;     // strays past the output register and the skid entry

   // -------------------------------------------------------------------------
   // Scoreboard: sorted window model and the medians still to arrive
   // -------------------------------------------------------------------------
   class median_scoreboard;
      sample_type win_value [WINDOW];
      age_type    win_age   [WINDOW];
      sample_type pending_medians [$];
      int         mismatch_count;
      int         medians_checked;

      function new();
         for (int i = 0; i < WINDOW; i++) begin
            win_value[i] = '0;
            win_age[i]   = age_type'(i);
         end
         mismatch_count  = 0;
         medians_checked = 0;
      endfunction

      // Retire the oldest entry, age the rest, insert the sample in order.
      function sample_type advance_window(sample_type s);
         sample_type x;
         int         oldest;
         int         pos;
         x      = (s == MARKER) ? SUBST : s;
         oldest = 0;
         for (int i = 1; i < WINDOW; i++) begin
            if (win_age[i] > win_age[oldest]) oldest = i;
         end
         for (int i = oldest; i < WINDOW - 1; i++) begin
            win_value[i] = win_value[i + 1];
            win_age[i]   = win_age[i + 1];
         end
         for (int i = 0; i < WINDOW - 1; i++) begin
            if (win_age[i] < AGE_MAX) win_age[i] = win_age[i] + 1'b1;
         end
         // equal values stay ahead of the new sample
         pos = WINDOW - 1;
         while (pos > 0 && win_value[pos - 1] > x) begin
            win_value[pos] = win_value[pos - 1];
            win_age[pos]   = win_age[pos - 1];
            pos--;
         end
         win_value[pos] = x;
         win_age[pos]   = '0;
         return win_value[MID];
      endfunction

      function void note_sample(sample_type s);
         pending_medians.push_back(advance_window(s));
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatch_count++;
      endtask

      task check_median(sample_type got);
         sample_type want;
         if (pending_medians.size() == 0) begin
            report_mismatch($sformatf("median %0d with no sample outstanding", got));
         end else begin
            want = pending_medians.pop_front();
            if (got !== want)
               report_mismatch($sformatf("median #%0d got %0d want %0d",
                                         medians_checked, got, want));
         end
         medians_checked++;
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block inputs (known from time zero)
   // -------------------------------------------------------------------------
   logic       clock;
   logic       reset      = 1'b1;
   logic       req_valid  = 1'b0;
   logic       req_stall;
   sample_type req_sample = '0;
   logic       rsp_valid;
   logic       rsp_stall  = 1'b0;
   sample_type rsp_median;

   median_scoreboard sb = new();

   running_median_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_median (rsp_median)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run when neither channel has moved for too long
   // -------------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Sender: offer one sample after a gap and hold it until taken.
   // Called at a rising edge; returns at the edge that accepts the sample,
   // so the next call drives either the next sample or a low valid, never
   // both in the same step.
   // -------------------------------------------------------------------------
   task automatic send_sample(input sample_type s, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      // hold the payload steady while the block stalls
      do @(posedge clock); while (req_stall);
      sb.note_sample(s);
   endtask

   // -------------------------------------------------------------------------
   // Receiver: stall for a drawn number of cycles, then take one median.
   // Some segments run without stalls; once, hold off for a long stretch so
   // the block fills up and pushes back on req.
   // -------------------------------------------------------------------------
   initial begin
      int  hold;
      int  medians_seen;
      bit  stall_mode;
      medians_seen = 0;
      stall_mode   = 1'b1;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (medians_seen % SEGMENT == 0) stall_mode = $urandom_range(0, 2) != 0;
         hold = stall_mode ? $urandom_range(0, 17) : 0;
         if (medians_seen == HOLD_AT) hold = HOLD_CYCLES;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_median(rsp_median);
         medians_seen++;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      sample_type directed [20];
      sample_type s;
      int         gap;
      int         level;
      bit         gap_mode;

      // Directed run: start-up with zero fill (marker samples included),
      // both extremes, runs of equal values, then mixed values.
      directed = '{
         12'd0,    12'd4095, 12'd1,    12'd4095, 12'd0,
         12'd2048, 12'd2048, 12'd2048, 12'd4095, 12'd1,
         12'd1,    12'd1,    12'd1,    12'd4094, 12'd2730,
         12'd1365, 12'd0,    12'd4095, 12'd2048, 12'd7
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_sample(directed[i], (i < 10) ? 0 : $urandom_range(0, 17));
      end

      level    = 2048;
      gap_mode = 1'b1;
      for (int n = 0; n < NUM_RANDOM; n++) begin
         // drift a level so nearby samples collide and reorder the window
         level = level + $urandom_range(0, 64) - 32;
         if (level < 0)    level = 0;
         if (level > 4095) level = 4095;
         case ($urandom_range(0, 9))
            0, 1, 2: s = sample_type'($urandom_range(0, 4095));
            3, 4, 5: s = sample_type'(level);
            6:       s = sample_type'($urandom_range(0, 1));
            7:       s = sample_type'($urandom_range(4094, 4095));
            8:       s = sample_type'((level & 12'hFF0) | $urandom_range(0, 2));
            default: s = sample_type'(level + $urandom_range(0, 4) < 4096 ?
                                      level + $urandom_range(0, 4) : 4095);
         endcase
         if (n % SEGMENT == 0) gap_mode = $urandom_range(0, 2) != 0;
         gap = gap_mode ? $urandom_range(0, 17) : 0;
         // keep offering back-to-back while the receiver holds off
         if (n >= BURST_FIRST && n < BURST_LAST) gap = 0;
         send_sample(s, gap);
      end
      req_valid <= 1'b0;

      // drain: wait for every pending median, then a few cycles for strays
      while (sb.pending_medians.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
